>>> hdl/i2cq_pkg.sv
// ----------------------------------------------------------------------------
// i2cq_pkg
// Shared command and status codes, controller states and the control and
// status bundles between the queue controller and its datapath.
// ----------------------------------------------------------------------------
package i2cq_pkg;

   typedef enum logic [2:0] {
      CMD_LOAD_BYTE = 3'd0,
      CMD_ADD       = 3'd1,
      CMD_POP       = 3'd2,
      CMD_CONTAINS  = 3'd3,
      CMD_GET_DATA  = 3'd4,
      CMD_SET_DATA  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FETCH  = 6'b000010,
      ST_EXEC   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_HEADRD = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan;
      logic emit;
   } ctrl_type;

   typedef struct packed {
      logic go_scan;
      logic scan_done;
      logic out_free;
   } stat_type;

endpackage

>>> hdl/i2cq_controller.sv
// ----------------------------------------------------------------------------
// i2cq_controller
// Command sequencer: fetch head entry, execute, optional ID scan, head
// readback and result hand-off.
// ----------------------------------------------------------------------------
module i2cq_controller import i2cq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = stat.go_scan ? ST_SCAN : ST_HEADRD;
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = ST_HEADRD;
         end
         ST_HEADRD: state_in = ST_DONE;
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign ctrl.capture = (state_ff == ST_IDLE) && req_tvalid;
   assign ctrl.exec    = (state_ff == ST_EXEC);
   assign ctrl.scan    = (state_ff == ST_SCAN);
   assign ctrl.emit    = (state_ff == ST_DONE) && stat.out_free;

endmodule

>>> hdl/i2cq_datapath.sv
// ----------------------------------------------------------------------------
// i2cq_datapath
// Descriptor and payload memories, ring pointers, ID counter, command
// execution, ID scan and the result register.
// ----------------------------------------------------------------------------
module i2cq_datapath import i2cq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int MAX_BYTES   = 16,
   parameter int ID_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   output stat_type    stat,
   input  logic [2:0]  req_tuser,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [1:0]  rsp_tuser,
   output logic [63:0] rsp_tdata
);

   localparam int PW        = $clog2(QUEUE_DEPTH);
   localparam int CW        = $clog2(QUEUE_DEPTH + 1);
   localparam int PAY_DEPTH = QUEUE_DEPTH * MAX_BYTES;
   localparam int PAW       = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // request capture
   cmd_type     cmd_ff;
   logic [6:0]  dev_ff;
   logic        rnw_ff;
   logic [4:0]  len_ff;
   logic [3:0]  off_ff;
   logic [7:0]  dat_ff;
   logic [15:0] qid_ff;

   // queue state
   logic [PW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in, nid_inc;

   // scan
   logic [PW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0] scan_cnt_ff, scan_cnt_in;
   logic          scan_pend_ff, scan_pend_in, scan_issue;

   // result
   status_type         status_ff, status_in;
   logic [ID_BITS-1:0] rid_ff, rid_in;
   logic               rid_head_ff, rid_head_in;
   logic               found_ff, found_in;
   logic [7:0]         dout_ff, dout_in;
   logic               rsp_tvalid_ff;
   logic [1:0]         rsp_tuser_ff;
   logic [63:0]        rsp_tdata_ff;

   // descriptor memory
   logic [6:0]         slot_addr_mem [QUEUE_DEPTH];
   logic               slot_read_mem [QUEUE_DEPTH];
   logic [4:0]         slot_len_mem  [QUEUE_DEPTH];
   logic [ID_BITS-1:0] slot_id_mem   [QUEUE_DEPTH];
   logic [6:0]         addr_rd_ff;
   logic               read_rd_ff;
   logic [4:0]         len_rd_ff;
   logic [ID_BITS-1:0] id_rd_ff;
   logic [PW-1:0]      slot_raddr;
   logic               slot_we;

   // payload memory
   logic [7:0]     pay_mem [PAY_DEPTH];
   logic [7:0]     pay_rd_ff;
   logic [PAW-1:0] pay_raddr, pay_waddr, tail_base;
   logic           pay_we;

   logic                full, empty, off_ok, off_in_len, id_hit;
   logic [ID_BITS+15:0] hid_ext, rid_ext;
   logic [CW+3:0]       cnt_ext;
   logic [15:0]         head_id16, rid16;
   logic [6:0]          head_addr;
   logic                head_read;
   logic [4:0]          head_len;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= cmd_type'(req_tuser);
         dev_ff <= req_tdata[6:0];
         rnw_ff <= req_tdata[7];
         len_ff <= req_tdata[12:8];
         off_ff <= req_tdata[16:13];
         dat_ff <= req_tdata[24:17];
         qid_ff <= req_tdata[40:25];
      end
   end

   assign slot_raddr = ctrl.scan ? scan_ptr_ff : head_ff;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_addr_mem[tail_ff] <= dev_ff;
         slot_read_mem[tail_ff] <= rnw_ff;
         slot_len_mem[tail_ff]  <= len_ff;
         slot_id_mem[tail_ff]   <= next_id_ff;
      end
      addr_rd_ff <= slot_addr_mem[slot_raddr];
      read_rd_ff <= slot_read_mem[slot_raddr];
      len_rd_ff  <= slot_len_mem[slot_raddr];
      id_rd_ff   <= slot_id_mem[slot_raddr];
   end

   assign pay_raddr = PAW'(32'(head_ff) * MAX_BYTES + 32'(off_ff));
   assign tail_base = PAW'(32'(tail_ff) * MAX_BYTES + 32'(off_ff));

   always_ff @(posedge clock) begin
      if (pay_we) pay_mem[pay_waddr] <= dat_ff;
      pay_rd_ff <= pay_mem[pay_raddr];
   end

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign off_ok     = 32'(off_ff) < MAX_BYTES;
   assign off_in_len = {1'b0, off_ff} < len_rd_ff;
   assign id_hit     = ({16'b0, id_rd_ff} == {{ID_BITS{1'b0}}, qid_ff});
   assign scan_issue = (scan_cnt_ff != count_ff);
   assign nid_inc    = next_id_ff + 1'b1;

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      next_id_in   = next_id_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_cnt_in  = scan_cnt_ff;
      scan_pend_in = scan_pend_ff;
      status_in    = status_ff;
      rid_in       = rid_ff;
      rid_head_in  = rid_head_ff;
      found_in     = found_ff;
      dout_in      = dout_ff;
      slot_we      = 1'b0;
      pay_we       = 1'b0;
      pay_waddr    = tail_base;
      if (ctrl.exec) begin
         status_in    = STAT_OK;
         rid_in       = '0;
         rid_head_in  = 1'b0;
         found_in     = 1'b0;
         dout_in      = '0;
         scan_ptr_in  = head_ff;
         scan_cnt_in  = '0;
         scan_pend_in = 1'b0;
         unique case (cmd_ff)
            CMD_LOAD_BYTE: begin
               if (full) status_in = STAT_FULL;
               else if (!off_ok) status_in = STAT_RANGE;
               else pay_we = 1'b1;
            end
            CMD_ADD: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else if (32'(len_ff) > MAX_BYTES) begin
                  status_in = STAT_RANGE;
               end else begin
                  slot_we    = 1'b1;
                  rid_in     = next_id_ff;
                  next_id_in = (nid_inc == '0) ? ID_BITS'(1) : nid_inc;
                  tail_in    = ring_next(tail_ff);
                  count_in   = count_ff + 1'b1;
               end
            end
            CMD_POP: begin
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  head_in     = ring_next(head_ff);
                  count_in    = count_ff - 1'b1;
                  rid_head_in = 1'b1;
               end
            end
            CMD_CONTAINS: begin
            end
            CMD_GET_DATA: begin
               if (empty) status_in = STAT_EMPTY;
               else if (off_in_len && off_ok) dout_in = pay_rd_ff;
            end
            CMD_SET_DATA: begin
               pay_waddr = pay_raddr;
               if (empty) status_in = STAT_EMPTY;
               else if (off_in_len && off_ok) pay_we = 1'b1;
               else status_in = STAT_RANGE;
            end
            default: begin
            end
         endcase
      end
      if (ctrl.scan) begin
         scan_pend_in = scan_issue;
         if (scan_issue) begin
            scan_ptr_in = ring_next(scan_ptr_ff);
            scan_cnt_in = scan_cnt_ff + 1'b1;
         end
         if (scan_pend_ff && id_hit) found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         next_id_ff    <= ID_BITS'(1);
         scan_ptr_ff   <= '0;
         scan_cnt_ff   <= '0;
         scan_pend_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         scan_ptr_ff  <= scan_ptr_in;
         scan_cnt_ff  <= scan_cnt_in;
         scan_pend_ff <= scan_pend_in;
         if (ctrl.emit) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rid_ff      <= rid_in;
      rid_head_ff <= rid_head_in;
      found_ff    <= found_in;
      dout_ff     <= dout_in;
   end

   assign hid_ext   = {16'b0, id_rd_ff};
   assign rid_ext   = {16'b0, rid_ff};
   assign cnt_ext   = {4'b0, count_ff};
   assign head_id16 = empty ? 16'b0 : hid_ext[15:0];
   assign head_addr = empty ? 7'b0 : addr_rd_ff;
   assign head_read = empty ? 1'b0 : read_rd_ff;
   assign head_len  = empty ? 5'b0 : len_rd_ff;
   assign rid16     = rid_head_ff ? head_id16 : rid_ext[15:0];

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_tuser_ff <= status_ff;
         rsp_tdata_ff <= {5'b0, empty, cnt_ext[3:0], head_id16, head_len, head_read,
                          head_addr, dout_ff, found_ff, rid16};
      end
   end

   assign stat.go_scan   = (cmd_ff == CMD_CONTAINS) && !empty && (qid_ff != 16'b0);
   assign stat.scan_done = !scan_issue && !scan_pend_ff;
   assign stat.out_free  = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

>>> hdl/i2c_transfer_command_queue.sv
// ----------------------------------------------------------------------------
// i2c_transfer_command_queue
// Ring queue of I2C transfer descriptors with payload bytes and wrapping IDs.
//
//   channel  direction  contents
//   req_*    in         one queue command and its operands
//   rsp_*    out        command status, results, head descriptor and count
//
// One command at a time: a command is captured, fetched, executed and its head
// entry read back before the result is registered at hand-off; the next command
// is taken the cycle after hand-off. Contains with a nonzero ID on a non-empty
// queue adds an ID scan through the single descriptor memory read port, one entry a cycle.
// Reset clears pointers and count and sets the ID counter to 1; memories are not cleared.
// A result held by rsp_tready low blocks the next command only at hand-off.
// ----------------------------------------------------------------------------
module i2c_transfer_command_queue import i2cq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int MAX_BYTES   = 16,
   parameter int ID_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd
   input  logic [2:0]  req_tuser,
   // target_addr, read_not_write, length, offset, data_byte, query_id, zero pad
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status
   output logic [1:0]  rsp_tuser,
   // result_id, found, data_out, head_addr, head_read, head_length, head_id,
   // entry_count, is_empty, zero pad
   output logic [63:0] rsp_tdata
);

   ctrl_type ctrl;
   stat_type stat;

   i2cq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   i2cq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_BYTES   (MAX_BYTES),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/sv/tb_i2c_transfer_command_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_transfer_command_queue
// Self-checking bench for the I2C transfer descriptor queue. A directed table
// covers the empty, full and out-of-range corners, then random traffic mixing
// load-then-add transfers with pops, reads, writes and ID queries runs against an in-bench queue model.
// ----------------------------------------------------------------------------
module tb_i2c_transfer_command_queue;
   import i2cq_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int N_DIRECTED     = 28;

   typedef struct {
      cmd_type     cmd;
      logic [6:0]  dev;
      logic        rnw;
      logic [4:0]  len;
      logic [3:0]  off;
      logic [7:0]  dat;
      logic [15:0] qid;
   } queue_cmd_type;

   typedef struct {
      status_type  status;
      logic [15:0] result_id;
      logic        found;
      logic [7:0]  data_out;
      logic [6:0]  head_addr;
      logic        head_read;
      logic [4:0]  head_length;
      logic [15:0] head_id;
      logic [3:0]  entry_count;
      logic        is_empty;
   } queue_rsp_type;

   typedef struct {
      cmd_type     cmd;
      logic [6:0]  dev;
      logic        rnw;
      logic [4:0]  len;
      logic [3:0]  off;
      logic [7:0]  dat;
      logic [15:0] qid;
      bit          typed;
      status_type  st;
      logic [15:0] rid;
      logic [3:0]  cnt;
   } directed_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = 3'd0;
   logic [47:0] req_tdata  = 48'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [1:0]  rsp_tuser;
   logic [63:0] rsp_tdata;

   // queue model state
   logic [6:0]  pq_addr   [8];
   logic        pq_read   [8];
   logic [4:0]  pq_len    [8];
   logic [15:0] pq_id     [8];
   logic [7:0]  pq_bytes  [128];
   bit          pq_loaded [128];
   logic [2:0]  pq_head;
   logic [2:0]  pq_tail;
   logic [3:0]  pq_fill;
   logic [15:0] pq_next_id;

   queue_rsp_type pending_rsp[$];
   int            mismatch_cnt = 0;
   int            items_sent   = 0;
   int            idle_cycles  = 0;
   int            stall_left   = 0;
   bit            idle_on      = 1'b1;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{CMD_POP,       7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_EMPTY, 16'd0, 4'd0},
      '{CMD_GET_DATA,  7'h00, 1'b0, 5'd0,  4'd15, 8'h00, 16'h0000, 1'b1, STAT_EMPTY, 16'd0, 4'd0},
      '{CMD_SET_DATA,  7'h00, 1'b0, 5'd0,  4'd0,  8'hFF, 16'h0000, 1'b1, STAT_EMPTY, 16'd0, 4'd0},
      '{CMD_CONTAINS,  7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd0, 4'd0},
      '{CMD_LOAD_BYTE, 7'h00, 1'b0, 5'd0,  4'd0,  8'hFF, 16'h0000, 1'b1, STAT_OK,    16'd0, 4'd0},
      '{CMD_LOAD_BYTE, 7'h00, 1'b0, 5'd0,  4'd15, 8'h00, 16'h0000, 1'b1, STAT_OK,    16'd0, 4'd0},
      '{CMD_ADD,       7'h7F, 1'b1, 5'd16, 4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd1, 4'd1},
      '{CMD_ADD,       7'h55, 1'b1, 5'd31, 4'd0,  8'h00, 16'h0000, 1'b1, STAT_RANGE, 16'd0, 4'd1},
      '{CMD_ADD,       7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd2, 4'd2},
      '{CMD_CONTAINS,  7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0001, 1'b0, STAT_OK,    16'd0, 4'd0},
      '{CMD_CONTAINS,  7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'hFFFF, 1'b0, STAT_OK,    16'd0, 4'd0},
      '{CMD_GET_DATA,  7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b0, STAT_OK,    16'd0, 4'd0},
      '{CMD_GET_DATA,  7'h00, 1'b0, 5'd0,  4'd15, 8'h00, 16'h0000, 1'b0, STAT_OK,    16'd0, 4'd0},
      '{CMD_SET_DATA,  7'h00, 1'b0, 5'd0,  4'd15, 8'hA5, 16'h0000, 1'b1, STAT_OK,    16'd0, 4'd2},
      '{CMD_POP,       7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd2, 4'd1},
      '{CMD_GET_DATA,  7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd0, 4'd1},
      '{CMD_SET_DATA,  7'h00, 1'b0, 5'd0,  4'd0,  8'h3C, 16'h0000, 1'b1, STAT_RANGE, 16'd0, 4'd1},
      '{CMD_ADD,       7'h01, 1'b1, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd3, 4'd2},
      '{CMD_ADD,       7'h02, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd4, 4'd3},
      '{CMD_ADD,       7'h04, 1'b1, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd5, 4'd4},
      '{CMD_ADD,       7'h08, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd6, 4'd5},
      '{CMD_ADD,       7'h10, 1'b1, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd7, 4'd6},
      '{CMD_ADD,       7'h20, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd8, 4'd7},
      '{CMD_ADD,       7'h40, 1'b1, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd9, 4'd8},
      '{CMD_ADD,       7'h7F, 1'b1, 5'd16, 4'd0,  8'h00, 16'h0000, 1'b1, STAT_FULL,  16'd0, 4'd8},
      '{CMD_LOAD_BYTE, 7'h00, 1'b0, 5'd0,  4'd3,  8'h77, 16'h0000, 1'b1, STAT_FULL,  16'd0, 4'd8},
      '{CMD_CONTAINS,  7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0009, 1'b0, STAT_OK,    16'd0, 4'd0},
      '{CMD_POP,       7'h00, 1'b0, 5'd0,  4'd0,  8'h00, 16'h0000, 1'b1, STAT_OK,    16'd3, 4'd7}
   };

   i2c_transfer_command_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic queue_rsp_type predict_queue_step(queue_cmd_type c);
      queue_rsp_type r;
      logic [2:0] p;
      r = '{STAT_OK, 16'd0, 1'b0, 8'd0, 7'd0, 1'b0, 5'd0, 16'd0, 4'd0, 1'b0};
      case (c.cmd)
         CMD_LOAD_BYTE: begin
            if (pq_fill == 4'd8) begin
               r.status = STAT_FULL;
            end else begin
               pq_bytes[{pq_tail, c.off}]  = c.dat;
               pq_loaded[{pq_tail, c.off}] = 1'b1;
            end
         end
         CMD_ADD: begin
            if (pq_fill == 4'd8) begin
               r.status = STAT_FULL;
            end else if (c.len > 5'd16) begin
               r.status = STAT_RANGE;
            end else begin
               pq_addr[pq_tail] = c.dev;
               pq_read[pq_tail] = c.rnw;
               pq_len[pq_tail]  = c.len;
               pq_id[pq_tail]   = pq_next_id;
               r.result_id      = pq_next_id;
               pq_next_id       = pq_next_id + 16'd1;
               if (pq_next_id == 16'd0) pq_next_id = 16'd1;
               pq_tail = pq_tail + 3'd1;
               pq_fill = pq_fill + 4'd1;
            end
         end
         CMD_POP: begin
            if (pq_fill == 4'd0) begin
               r.status = STAT_EMPTY;
            end else begin
               pq_head = pq_head + 3'd1;
               pq_fill = pq_fill - 4'd1;
               if (pq_fill != 4'd0) r.result_id = pq_id[pq_head];
            end
         end
         CMD_CONTAINS: begin
            p = pq_head;
            for (int i = 0; i < pq_fill; i++) begin
               if (c.qid != 16'd0 && pq_id[p] == c.qid) r.found = 1'b1;
               p = p + 3'd1;
            end
         end
         CMD_GET_DATA: begin
            if (pq_fill == 4'd0) r.status = STAT_EMPTY;
            else if (c.off < pq_len[pq_head]) r.data_out = pq_bytes[{pq_head, c.off}];
         end
         CMD_SET_DATA: begin
            if (pq_fill == 4'd0) begin
               r.status = STAT_EMPTY;
            end else if (c.off < pq_len[pq_head]) begin
               pq_bytes[{pq_head, c.off}]  = c.dat;
               pq_loaded[{pq_head, c.off}] = 1'b1;
            end else begin
               r.status = STAT_RANGE;
            end
         end
         default: ;
      endcase
      if (pq_fill != 4'd0) begin
         r.head_addr   = pq_addr[pq_head];
         r.head_read   = pq_read[pq_head];
         r.head_length = pq_len[pq_head];
         r.head_id     = pq_id[pq_head];
      end
      r.entry_count = pq_fill;
      r.is_empty    = (pq_fill == 4'd0);
      return r;
   endfunction

   function automatic queue_cmd_type rand_fields(cmd_type k);
      queue_cmd_type c;
      c.cmd = k;
      c.dev = 7'($urandom_range(0, 127));
      c.rnw = 1'($urandom_range(0, 1));
      c.len = 5'($urandom_range(0, 31));
      c.off = 4'($urandom_range(0, 15));
      c.dat = 8'($urandom_range(0, 255));
      c.qid = 16'($urandom_range(0, 65535));
      return c;
   endfunction

   function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_cnt++;
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      end
   endfunction

   task automatic drive_cmd(input queue_cmd_type c, input bit typed = 1'b0,
                            input status_type st = STAT_OK, input logic [15:0] rid = 16'd0,
                            input logic [3:0] cnt = 4'd0);
      queue_rsp_type e;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.cmd;
      req_tdata  <= {7'd0, c.qid, c.dat, c.off, c.len, c.rnw, c.dev};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      e = predict_queue_step(c);
      if (typed) begin
         e.status      = st;
         e.result_id   = rid;
         e.entry_count = cnt;
      end
      pending_rsp.push_back(e);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // stage payload bytes in order, then append the descriptor
   task automatic send_transfer();
      queue_cmd_type c;
      int n;
      n = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(0, 16);
      for (int o = 0; o < n; o++) begin
         if ($urandom_range(0, 15) != 0) begin
            c = rand_fields(CMD_LOAD_BYTE);
            c.off = 4'(o);
            drive_cmd(c);
         end
      end
      c = rand_fields(CMD_ADD);
      c.len = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31)) : 5'(n);
      drive_cmd(c);
   endtask

   // never read a head byte that was not written
   task automatic send_get();
      queue_cmd_type c;
      bit safe;
      c = rand_fields(CMD_GET_DATA);
      safe = 1'b0;
      for (int t = 0; t < 8 && !safe; t++) begin
         safe = (pq_fill == 4'd0) || (c.off >= pq_len[pq_head])
                || pq_loaded[{pq_head, c.off}];
         if (!safe) c.off = 4'($urandom_range(0, 15));
      end
      if (!safe) c.cmd = CMD_SET_DATA;
      drive_cmd(c);
   endtask

   task automatic send_contains();
      queue_cmd_type c;
      int sel;
      c = rand_fields(CMD_CONTAINS);
      sel = $urandom_range(0, 9);
      if (sel < 5 && pq_fill != 4'd0)
         c.qid = pq_id[3'(pq_head + 3'($urandom_range(0, pq_fill - 1)))];
      else if (sel == 5) c.qid = 16'd0;
      else if (sel == 6) c.qid = pq_next_id;
      else if (sel == 7) c.qid = pq_next_id - 16'd1;
      drive_cmd(c);
   endtask

   task automatic run_random(input int count, input int calm_from, input int calm_to);
      int start;
      int sel;
      start = items_sent;
      while (items_sent - start < count) begin
         idle_on = !((items_sent - start) >= calm_from && (items_sent - start) < calm_to);
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            send_transfer();
         end else if (sel < 48 || (pq_fill >= 4'd6 && sel < 60)) begin
            repeat ($urandom_range(1, 3)) drive_cmd(rand_fields(CMD_POP));
         end else if (sel < 52) begin
            while (pq_fill != 4'd0) drive_cmd(rand_fields(CMD_POP));
            drive_cmd(rand_fields(CMD_POP));
         end else if (sel < 68) begin
            send_get();
         end else if (sel < 80) begin
            drive_cmd(rand_fields(CMD_SET_DATA));
         end else if (sel < 93) begin
            send_contains();
         end else if (sel < 96) begin
            drive_cmd(rand_fields(CMD_ADD));
         end else begin
            drive_cmd(rand_fields(CMD_LOAD_BYTE));
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 6);
      rsp_tready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      queue_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            mismatch_cnt++;
            $error("response transaction with no command outstanding");
         end else begin
            e = pending_rsp.pop_front();
            check_field("status",      16'(e.status),      16'(rsp_tuser));
            check_field("result_id",   e.result_id,        rsp_tdata[15:0]);
            check_field("found",       16'(e.found),       16'(rsp_tdata[16]));
            check_field("data_out",    16'(e.data_out),    16'(rsp_tdata[24:17]));
            check_field("head_addr",   16'(e.head_addr),   16'(rsp_tdata[31:25]));
            check_field("head_read",   16'(e.head_read),   16'(rsp_tdata[32]));
            check_field("head_length", 16'(e.head_length), 16'(rsp_tdata[37:33]));
            check_field("head_id",     e.head_id,          rsp_tdata[53:38]);
            check_field("entry_count", 16'(e.entry_count), 16'(rsp_tdata[57:54]));
            check_field("is_empty",    16'(e.is_empty),    16'(rsp_tdata[58]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      queue_cmd_type c;
      pq_head    = 3'd0;
      pq_tail    = 3'd0;
      pq_fill    = 4'd0;
      pq_next_id = 16'd1;
      foreach (pq_loaded[i]) pq_loaded[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         c.cmd = directed_rows[i].cmd;
         c.dev = directed_rows[i].dev;
         c.rnw = directed_rows[i].rnw;
         c.len = directed_rows[i].len;
         c.off = directed_rows[i].off;
         c.dat = directed_rows[i].dat;
         c.qid = directed_rows[i].qid;
         drive_cmd(c, directed_rows[i].typed, directed_rows[i].st,
                   directed_rows[i].rid, directed_rows[i].cnt);
      end

      run_random(900, 300, 420);

      // hold off until every transaction has returned
      wait_for_drain();

      run_random(820, 570, 820);

      idle_on = 1'b0;
      wait_for_drain();
      repeat (16) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
hdl/i2cq_pkg.sv
hdl/i2cq_controller.sv
hdl/i2cq_datapath.sv
hdl/i2c_transfer_command_queue.sv
tb/sv/tb_i2c_transfer_command_queue.sv
